// ----- src/indexed_insert_remove_list_unit_assert.svh -----
// Assertion macros for the indexed insert/remove list unit.
`ifndef INDEXED_INSERT_REMOVE_LIST_UNIT_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IIRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/iirl_pkg.sv -----
// Shared codes and types for the indexed insert/remove list unit.
package iirl_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CMD_HOLD  = 2'd0;
  localparam cell_cmd_t CMD_LOAD  = 2'd1;
  localparam cell_cmd_t CMD_LEFT  = 2'd2;
  localparam cell_cmd_t CMD_RIGHT = 2'd3;

endpackage

// ----- src/indexed_insert_remove_list_unit.sv -----
// Top level: indexed insert/remove list built from a row of entry cells.
// The result appears on the output register in the cycle after the input transfer.
// Throughput: one request per cycle while the output register drains; the whole cell row shifts at once.
// A request is taken whenever the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents are left as is.
module indexed_insert_remove_list_unit import iirl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [5:0]         index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [6:0]         count
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > 7) ? LW : 7;
  localparam int RD_CELLS = (CAPACITY > 64) ? 64 : CAPACITY;
  localparam int IW = (RD_CELLS > 1) ? $clog2(RD_CELLS) : 1;

  logic [LW-1:0] len;
  logic [LW-1:0] len_next;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] len_next_ext;
  logic          full;
  logic          in_fire;
  logic          do_append;
  logic          do_insert;
  logic          do_remove;
  logic [1:0]    st_next;
  logic [31:0]   rd_next;

  logic signed [31:0] cell_q [CAPACITY];
  logic signed [31:0] rd_view [RD_CELLS];
  cell_cmd_t          cell_cmd [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign len_ext  = CW'(len);
  assign idx_ext  = CW'(index);
  assign full     = (len == LW'(CAPACITY));

  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    st_next   = ST_OK;
    rd_next   = '0;
    len_next  = len;
    unique case (mode)
      MODE_APPEND: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          do_append = 1'b1;
          len_next  = len + LW'(1);
        end
      end
      MODE_INSERT: begin
        if (idx_ext > len_ext) begin
          st_next = ST_RANGE;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          do_insert = 1'b1;
          len_next  = len + LW'(1);
        end
      end
      MODE_REMOVE: begin
        if (idx_ext >= len_ext) begin
          st_next = ST_RANGE;
        end else begin
          do_remove = 1'b1;
          len_next  = len - LW'(1);
        end
      end
      default: begin
        if (idx_ext >= len_ext) begin
          st_next = ST_RANGE;
          rd_next = MOST_NEGATIVE;
        end else begin
          rd_next = rd_view[index[IW-1:0]];
        end
      end
    endcase
  end

  assign len_next_ext = CW'(len_next);

  genvar g;
  generate
    for (g = 0; g < RD_CELLS; g++) begin : g_view
      assign rd_view[g] = cell_q[g];
    end

    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;

      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_q[g+1];
      end

      always_comb begin
        cell_cmd[g] = CMD_HOLD;
        if (in_fire) begin
          if (do_append && (CW'(g) == len_ext)) begin
            cell_cmd[g] = CMD_LOAD;
          end else if (do_insert && (CW'(g) == idx_ext)) begin
            cell_cmd[g] = CMD_LOAD;
          end else if (do_insert && (CW'(g) > idx_ext) && (CW'(g) <= len_ext)) begin
            cell_cmd[g] = CMD_LEFT;
          end else if (do_remove && (CW'(g) >= idx_ext) && (CW'(g) + CW'(1) < len_ext)) begin
            cell_cmd[g] = CMD_RIGHT;
          end
        end
      end

      iirl_cell u_cell (
        .clk        (clk),
        .cmd        (cell_cmd[g]),
        .load_data  (value),
        .from_left  (left_d),
        .from_right (right_d),
        .q          (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        len       <= len_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_value <= rd_next;
      status     <= st_next;
      count      <= len_next_ext[6:0];
    end
  end

`include "indexed_insert_remove_list_unit_assert.svh"

  `IIRL_ASSERT_NOW(a_len_bound, 1'b1, len <= LW'(CAPACITY), "entry count above capacity")
  `IIRL_ASSERT_NEXT(a_append_grows, in_fire && mode == MODE_APPEND && !full, len == $past(len) + LW'(1), "append did not grow list")
  `IIRL_ASSERT_NEXT(a_read_keeps, in_fire && mode == MODE_READ, $stable(len), "read changed entry count")
  `IIRL_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, count == 7'(CW'(CAPACITY)), "full status with wrong count")

endmodule

// ----- src/iirl_cell.sv -----
// One entry cell of the list row: holds, loads, or takes a neighbor's entry.
module iirl_cell import iirl_pkg::*; (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic signed [31:0] load_data,
  input  logic signed [31:0] from_left,
  input  logic signed [31:0] from_right,
  output logic signed [31:0] q
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD:  q <= load_data;
      CMD_LEFT:  q <= from_left;
      CMD_RIGHT: q <= from_right;
      default:   q <= q;
    endcase
  end

endmodule
